/* hw/rtl/lhs_pkg.sv */
// lhs_pkg: shared types, constants and preset table of the link health supervisor
// used by lhs_ctrl, lhs_datapath and link_health_supervisor; no dependencies
`default_nettype none

package lhs_pkg;

    localparam int WINDOW    = 10;
    localparam int SAMPLE_W  = 20;
    localparam int FAIL_W    = 8;
    localparam int TIME_W    = 32;
    localparam int HEAD_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W     = SAMPLE_W + CNT_W;
    // divider retires two quotient bits per cycle
    localparam int DIV_W     = SUM_W + (SUM_W % 2);
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MONITORING_ON = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SET    = 1'd1;

    localparam logic [FAIL_W-1:0]   FAIL_MAX        = '1;
    localparam logic [FAIL_W-1:0]   ERR_POOR_FAILS  = 8'd3;
    localparam logic [SAMPLE_W-1:0] AVG_EXCELLENT   = 20'd1000;
    localparam logic [SAMPLE_W-1:0] AVG_GOOD        = 20'd3000;
    localparam logic [SAMPLE_W-1:0] AVG_FAIR        = 20'd8000;
    localparam logic [FAIL_W-1:0]   FAILS_GOOD      = 8'd1;
    localparam logic [FAIL_W-1:0]   FAILS_FAIR      = 8'd3;

    typedef enum logic [2:0] {
        OP_HEARTBEAT = 3'd0,
        OP_READ_DONE = 3'd1,
        OP_WRITE_DONE = 3'd2,
        OP_ERROR     = 3'd3,
        OP_LINK      = 3'd4,
        OP_QUALITY   = 3'd5,
        OP_RETRY     = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        Q_UNKNOWN   = 3'd0,
        Q_EXCELLENT = 3'd1,
        Q_GOOD      = 3'd2,
        Q_FAIR      = 3'd3,
        Q_POOR      = 3'd4
    } quality_t;

    typedef enum logic [1:0] {
        MODE_DEFAULT = 2'd0,
        MODE_GOOD    = 2'd1,
        MODE_POOR    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_OUT  = 2'd2
    } state_t;

    typedef struct packed {
        logic [15:0] delay_ms;
        logic [7:0]  retries;
        logic [15:0] connect_ms;
        logic [15:0] request_ms;
        logic [15:0] beat_ms;
    } preset_t;

    // first member sits in the highest bits
    typedef struct packed {
        logic                quality_changed;
        logic [15:0]         heartbeat_period_ms;
        logic [15:0]         request_timeout_ms;
        logic [15:0]         connect_timeout_ms;
        logic [7:0]          retry_limit;
        logic [15:0]         retry_delay_ms;
        logic                reconnect_request;
        logic                read_request;
        logic [SAMPLE_W-1:0] average_ms;
        logic [FAIL_W-1:0]   failure_count;
        logic [1:0]          preset_mode;
        logic [2:0]          quality;
    } result_t;

    localparam int RES_W    = $bits(result_t);
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;
    localparam int S_DATA_W = ((1 + TIME_W + 7) / 8) * 8;

    typedef struct packed {
        logic apply;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic div_last;
    } status_t;

    function automatic preset_t preset_of(input mode_t mode);
        preset_t p;
        case (mode)
            MODE_GOOD: p = '{16'd1000, 8'd3, 16'd5000, 16'd3000, 16'd60000};
            MODE_POOR: p = '{16'd3000, 8'd8, 16'd15000, 16'd12000, 16'd20000};
            default:   p = '{16'd2000, 8'd5, 16'd10000, 16'd8000, 16'd30000};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/lhs_ctrl.sv */
// lhs_ctrl: sequencer of the link health supervisor and output valid flag
// depends on lhs_pkg
`default_nettype none

module lhs_ctrl
    import lhs_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.apply  = 1'b1;
                    state_next = status.push ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // result register free or being drained this cycle
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

/* hw/rtl/lhs_datapath.sv */
// lhs_datapath: supervisor state, response-time ring, radix-4 average divider
// and result register; depends on lhs_pkg
`default_nettype none

module lhs_datapath
    import lhs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
    input  wire op_t                  s_op,
    input  wire logic                 s_outcome,
    input  wire logic [TIME_W-1:0]    s_time,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    output result_t                   result
);

    logic monitoring_reg, target_reg;

    mode_t               mode_reg, mode_next;
    quality_t            quality_reg, quality_next;
    logic [FAIL_W-1:0]   fail_reg, fail_next;
    logic [TIME_W-1:0]   beat_start_reg, beat_start_next;
    logic                beat_pending_reg, beat_pending_next;
    logic [SAMPLE_W-1:0] ring_reg [WINDOW];
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [HEAD_W-1:0]   head_reg, head_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] average_reg;
    logic                rd_reg, rd_next;
    logic                rc_reg, rc_next;
    logic                qc_reg, qc_next;
    result_t             result_reg;

    logic [DIV_W-1:0]    div_q_reg;
    logic [CNT_W-1:0]    div_r_reg;
    logic [CNT_W-1:0]    div_d_reg;
    logic [STEP_W-1:0]   div_cnt_reg;

    logic [FAIL_W-1:0]   fail_inc;
    logic [TIME_W-1:0]   diff;
    logic [SAMPLE_W-1:0] rt;
    logic                push;
    logic                full;
    quality_t            q_class;
    preset_t             cur_preset;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            monitoring_reg <= 1'b0;
            target_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MONITORING_ON: monitoring_reg <= cfg_wdata[0];
                CFG_TARGET_SET:    target_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign fail_inc = (fail_reg == FAIL_MAX) ? fail_reg : fail_reg + 1'b1;
    assign diff     = s_time - beat_start_reg;
    assign rt       = (|diff[TIME_W-1:SAMPLE_W]) ? '1 : diff[SAMPLE_W-1:0];
    assign full     = (count_reg >= CNT_W'(WINDOW));
    assign push     = (s_op == OP_READ_DONE) && s_outcome && beat_pending_reg;
    assign cur_preset = preset_of(mode_reg);

    always_comb begin
        if (fail_reg == '0 && average_reg < AVG_EXCELLENT) begin
            q_class = Q_EXCELLENT;
        end else if (fail_reg <= FAILS_GOOD && average_reg < AVG_GOOD) begin
            q_class = Q_GOOD;
        end else if (fail_reg <= FAILS_FAIR && average_reg < AVG_FAIR) begin
            q_class = Q_FAIR;
        end else begin
            q_class = Q_POOR;
        end
    end

    // event handling, applied at the accepting edge
    always_comb begin
        mode_next         = mode_reg;
        quality_next      = quality_reg;
        fail_next         = fail_reg;
        beat_start_next   = beat_start_reg;
        beat_pending_next = beat_pending_reg;
        rd_next           = 1'b0;
        rc_next           = 1'b0;
        qc_next           = 1'b0;
        case (s_op)
            OP_HEARTBEAT: begin
                if (monitoring_reg) begin
                    if (s_outcome) begin
                        beat_start_next   = s_time;
                        beat_pending_next = 1'b1;
                        rd_next           = 1'b1;
                    end else if (target_reg) begin
                        rc_next   = 1'b1;
                        fail_next = fail_inc;
                        if (fail_inc >= cur_preset.retries) begin
                            mode_next = MODE_POOR;
                            fail_next = '0;
                        end
                    end
                end
            end
            OP_READ_DONE: begin
                if (s_outcome) begin
                    if (beat_pending_reg) begin
                        beat_pending_next = 1'b0;
                        beat_start_next   = '0;
                    end
                    fail_next = '0;
                end else begin
                    fail_next = fail_inc;
                end
            end
            OP_WRITE_DONE: begin
                fail_next = s_outcome ? '0 : fail_inc;
            end
            OP_ERROR: begin
                fail_next = fail_inc;
                if (s_outcome && fail_inc >= ERR_POOR_FAILS) begin
                    mode_next = MODE_POOR;
                end
            end
            OP_LINK: begin
                if (s_outcome) begin
                    fail_next = '0;
                end else if (monitoring_reg && target_reg) begin
                    rc_next   = 1'b1;
                    fail_next = fail_inc;
                    if (fail_inc >= cur_preset.retries) begin
                        mode_next = MODE_POOR;
                        fail_next = '0;
                    end
                end
            end
            OP_QUALITY: begin
                if (monitoring_reg && q_class != quality_reg) begin
                    quality_next = q_class;
                    mode_next    = (q_class >= Q_FAIR) ? MODE_POOR : MODE_GOOD;
                    qc_next      = 1'b1;
                end
            end
            OP_RETRY: begin
                if (target_reg && s_outcome) begin
                    fail_next = '0;
                end
            end
            default: ;
        endcase
    end

    // ring bookkeeping for a new response time
    always_comb begin
        count_next = full ? count_reg : count_reg + 1'b1;
        head_next  = (head_reg == HEAD_W'(WINDOW - 1)) ? '0 : head_reg + 1'b1;
        sum_next   = sum_reg - (full ? SUM_W'(ring_reg[head_reg]) : '0) + SUM_W'(rt);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_DEFAULT;
            quality_reg      <= Q_UNKNOWN;
            fail_reg         <= '0;
            beat_start_reg   <= '0;
            beat_pending_reg <= 1'b0;
            count_reg        <= '0;
            head_reg         <= '0;
            sum_reg          <= '0;
        end else if (cmd.apply) begin
            mode_reg         <= mode_next;
            quality_reg      <= quality_next;
            fail_reg         <= fail_next;
            beat_start_reg   <= beat_start_next;
            beat_pending_reg <= beat_pending_next;
            if (push) begin
                count_reg <= count_next;
                head_reg  <= head_next;
                sum_reg   <= sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply && push) begin
            ring_reg[head_reg] <= rt;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            rd_reg <= rd_next;
            rc_reg <= rc_next;
            qc_reg <= qc_next;
        end
    end

    // restoring divider, two quotient bits per step
    logic [CNT_W:0]   r1, r2;
    logic [CNT_W-1:0] r1_sub;
    logic             b1, b0;
    logic [DIV_W-1:0] q_step;

    always_comb begin
        r1     = {div_r_reg, div_q_reg[DIV_W-1]};
        b1     = (r1 >= {1'b0, div_d_reg});
        r1_sub = b1 ? CNT_W'(r1 - {1'b0, div_d_reg}) : r1[CNT_W-1:0];
        r2     = {r1_sub, div_q_reg[DIV_W-2]};
        b0     = (r2 >= {1'b0, div_d_reg});
        q_step = {div_q_reg[DIV_W-3:0], b1, b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
            average_reg <= '0;
        end else if (cmd.apply && push) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (status.div_last) begin
                average_reg <= q_step[SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply && push) begin
            div_q_reg <= DIV_W'(sum_next);
            div_r_reg <= '0;
            div_d_reg <= count_next;
        end else if (cmd.div_step) begin
            div_q_reg <= q_step;
            div_r_reg <= b0 ? CNT_W'(r2 - {1'b0, div_d_reg}) : r2[CNT_W-1:0];
        end
    end

    assign status.push     = push;
    assign status.div_last = (div_cnt_reg == STEP_W'(DIV_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            result_reg.quality_changed     <= qc_reg;
            result_reg.heartbeat_period_ms <= cur_preset.beat_ms;
            result_reg.request_timeout_ms  <= cur_preset.request_ms;
            result_reg.connect_timeout_ms  <= cur_preset.connect_ms;
            result_reg.retry_limit         <= cur_preset.retries;
            result_reg.retry_delay_ms      <= cur_preset.delay_ms;
            result_reg.reconnect_request   <= rc_reg;
            result_reg.read_request        <= rd_reg;
            result_reg.average_ms          <= average_reg;
            result_reg.failure_count       <= fail_reg;
            result_reg.preset_mode         <= mode_reg;
            result_reg.quality             <= quality_reg;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

/* hw/rtl/link_health_supervisor.sv */
// link_health_supervisor: top level, joins lhs_ctrl and lhs_datapath
// depends on lhs_pkg, lhs_ctrl, lhs_datapath
//
// One link event enters per transfer and gives exactly one result transfer
// showing the supervisor state after the event. The event is applied in the
// cycle that accepts it, in ST_IDLE; ST_OUT then loads its result into the
// output register, and no new event is taken until the block is back in
// ST_IDLE. A successful read that closes a pending heartbeat first passes
// through ST_DIV, where the divider forms the new average of the response-time
// window at two quotient bits per cycle. The result waits in an output
// register, so the next event is taken while the previous result is still
// unclaimed; that event then holds in ST_OUT until the previous result has
// been taken. Configuration writes take effect at the clock edge where
// cfg_wr_en is high and are expected only while the block is idle.
`default_nettype none

module link_health_supervisor
    import lhs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,   // 0 monitoring_on, 1 target_set
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata: outcome [0], time_ms [32:1], zero pad above
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // s_tuser: opcode [2:0]
    input  wire logic [2:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata: quality [2:0], preset_mode [4:3], failure_count [12:5],
    // average_ms [32:13], read_request [33], reconnect_request [34],
    // retry_delay_ms [50:35], retry_limit [58:51], connect_timeout_ms [74:59],
    // request_timeout_ms [90:75], heartbeat_period_ms [106:91],
    // quality_changed [107], zero pad above
    output logic [M_DATA_W-1:0]       m_tdata
);

    cmd_t    cmd;
    status_t status;
    result_t result;

    lhs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lhs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_op      (op_t'(s_tuser)),
        .s_outcome (s_tdata[0]),
        .s_time    (s_tdata[TIME_W:1]),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    assign m_tdata = M_DATA_W'(result);

endmodule

`default_nettype wire

/* test/tb_link_health_supervisor.sv */
// tb_link_health_supervisor: self-checking testbench for link_health_supervisor
// holds its own prediction of the supervisor state and checks every result transfer
// depends on lhs_pkg and link_health_supervisor

module tb_link_health_supervisor
    import lhs_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic [2:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;

    link_health_supervisor u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    int send_idle_pct = 36;
    int recv_idle_pct = 81;
    int n_errors      = 0;
    logic [31:0] now_ms = '0;

    result_t expected_status[$];

    // predicted supervisor state
    bit                  mon_on  = 1'b0;
    bit                  tgt_set = 1'b0;
    mode_t               p_mode    = MODE_DEFAULT;
    quality_t            p_quality = Q_UNKNOWN;
    logic [7:0]          p_fails   = '0;
    logic [31:0]         p_beat_start = '0;
    bit                  p_beat_pending = 1'b0;
    logic [SAMPLE_W-1:0] p_ring [WINDOW];
    int                  p_count = 0;
    int                  p_head  = 0;
    logic [23:0]         p_sum   = '0;
    logic [SAMPLE_W-1:0] p_avg   = '0;

    function automatic int retries_for(mode_t m);
        case (m)
            MODE_GOOD: return 3;
            MODE_POOR: return 8;
            default:   return 5;
        endcase
    endfunction

    function automatic void bump_failures();
        if (p_fails != 8'hFF)
            p_fails = p_fails + 8'd1;
    endfunction

    function automatic bit attempt_reconnect();
        if (!tgt_set)
            return 1'b0;
        bump_failures();
        if (p_fails >= retries_for(p_mode)) begin
            p_mode  = MODE_POOR;
            p_fails = '0;
        end
        return 1'b1;
    endfunction

    function automatic result_t next_link_status(op_t op, bit ok, logic [31:0] t);
        result_t             r;
        bit                  rd;
        bit                  rc;
        bit                  qc;
        logic [31:0]         span;
        logic [SAMPLE_W-1:0] sample;
        quality_t            q;
        rd = 1'b0;
        rc = 1'b0;
        qc = 1'b0;
        case (op)
            OP_HEARTBEAT: begin
                if (mon_on) begin
                    if (!ok) begin
                        rc = attempt_reconnect();
                    end else begin
                        p_beat_start   = t;
                        p_beat_pending = 1'b1;
                        rd = 1'b1;
                    end
                end
            end
            OP_READ_DONE: begin
                if (ok) begin
                    if (p_beat_pending) begin
                        span   = t - p_beat_start;
                        sample = (span > 32'h000F_FFFF) ? 20'hF_FFFF : span[SAMPLE_W-1:0];
                        if (p_count >= WINDOW)
                            p_sum = p_sum - p_ring[p_head];
                        else
                            p_count++;
                        p_ring[p_head] = sample;
                        p_sum  = p_sum + sample;
                        p_head = (p_head + 1) % WINDOW;
                        p_avg  = SAMPLE_W'(p_sum / 24'(p_count));
                        p_beat_pending = 1'b0;
                        p_beat_start   = '0;
                    end
                    p_fails = '0;
                end else begin
                    bump_failures();
                end
            end
            OP_WRITE_DONE: begin
                if (ok)
                    p_fails = '0;
                else
                    bump_failures();
            end
            OP_ERROR: begin
                bump_failures();
                if (ok && p_fails >= 8'd3)
                    p_mode = MODE_POOR;
            end
            OP_LINK: begin
                if (ok)
                    p_fails = '0;
                else if (mon_on)
                    rc = attempt_reconnect();
            end
            OP_QUALITY: begin
                if (mon_on) begin
                    if (p_fails == 0 && p_avg < 1000)
                        q = Q_EXCELLENT;
                    else if (p_fails <= 1 && p_avg < 3000)
                        q = Q_GOOD;
                    else if (p_fails <= 3 && p_avg < 8000)
                        q = Q_FAIR;
                    else
                        q = Q_POOR;
                    if (q != p_quality) begin
                        p_quality = q;
                        p_mode    = (q == Q_FAIR || q == Q_POOR) ? MODE_POOR : MODE_GOOD;
                        qc = 1'b1;
                    end
                end
            end
            OP_RETRY: begin
                if (tgt_set && ok)
                    p_fails = '0;
            end
            default: ;
        endcase

        r = '0;
        r.quality           = p_quality;
        r.preset_mode       = p_mode;
        r.failure_count     = p_fails;
        r.average_ms        = p_avg;
        r.read_request      = rd;
        r.reconnect_request = rc;
        r.quality_changed   = qc;
        r.retry_limit       = 8'(retries_for(p_mode));
        case (p_mode)
            MODE_GOOD: begin
                r.retry_delay_ms      = 16'd1000;
                r.connect_timeout_ms  = 16'd5000;
                r.request_timeout_ms  = 16'd3000;
                r.heartbeat_period_ms = 16'd60000;
            end
            MODE_POOR: begin
                r.retry_delay_ms      = 16'd3000;
                r.connect_timeout_ms  = 16'd15000;
                r.request_timeout_ms  = 16'd12000;
                r.heartbeat_period_ms = 16'd20000;
            end
            default: begin
                r.retry_delay_ms      = 16'd2000;
                r.connect_timeout_ms  = 16'd10000;
                r.request_timeout_ms  = 16'd8000;
                r.heartbeat_period_ms = 16'd30000;
            end
        endcase
        return r;
    endfunction

    // result side
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    task automatic check_status(result_t want, result_t got);
        compare_field("quality", want.quality, got.quality);
        compare_field("preset_mode", want.preset_mode, got.preset_mode);
        compare_field("failure_count", want.failure_count, got.failure_count);
        compare_field("average_ms", want.average_ms, got.average_ms);
        compare_field("read_request", want.read_request, got.read_request);
        compare_field("reconnect_request", want.reconnect_request, got.reconnect_request);
        compare_field("retry_delay_ms", want.retry_delay_ms, got.retry_delay_ms);
        compare_field("retry_limit", want.retry_limit, got.retry_limit);
        compare_field("connect_timeout_ms", want.connect_timeout_ms, got.connect_timeout_ms);
        compare_field("request_timeout_ms", want.request_timeout_ms, got.request_timeout_ms);
        compare_field("heartbeat_period_ms", want.heartbeat_period_ms,
                      got.heartbeat_period_ms);
        compare_field("quality_changed", want.quality_changed, got.quality_changed);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_status.size() == 0) begin
                $error("result transfer with no event outstanding");
                n_errors++;
            end else begin
                check_status(expected_status.pop_front(), result_t'(m_tdata[RES_W-1:0]));
            end
        end
    end

    // event side: valid stays high across back-to-back transfers
    task automatic send_event(op_t op, bit ok, logic [31:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_DATA_W - 33){1'b0}}, t, ok};
        do @(posedge aclk); while (!s_tready);
        expected_status.push_back(next_link_status(op, ok, t));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge aclk);
        // covers the divider pass of a read that closes a heartbeat
        repeat (20) @(posedge aclk);
    endtask

    task automatic apply_settings(bit mon, bit tgt);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MONITORING_ON;
        cfg_wdata <= mon;
        @(posedge aclk);
        cfg_index <= CFG_TARGET_SET;
        cfg_wdata <= tgt;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mon_on  = mon;
        tgt_set = tgt;
    endtask

    task automatic test_monitoring_off();
        apply_settings(1'b0, 1'b0);
        for (int op = 0; op <= 6; op++) begin
            send_event(op_t'(op), 1'b0, 32'h0000_0000);
            send_event(op_t'(op), 1'b1, 32'hFFFF_FFFF);
        end
    endtask

    task automatic test_response_window();
        apply_settings(1'b1, 1'b1);
        send_event(OP_WRITE_DONE, 1'b1, 32'd100);
        // response time across the timestamp wrap
        send_event(OP_HEARTBEAT, 1'b1, 32'hFFFF_FF00);
        send_event(OP_READ_DONE, 1'b1, 32'h0000_0100);
        // a second heartbeat replaces the pending one
        send_event(OP_HEARTBEAT, 1'b1, 32'd1000);
        send_event(OP_HEARTBEAT, 1'b1, 32'd1005);
        send_event(OP_READ_DONE, 1'b1, 32'd1905);
        send_event(OP_READ_DONE, 1'b1, 32'd2000);
        // response time saturates
        send_event(OP_HEARTBEAT, 1'b1, 32'h0000_0000);
        send_event(OP_READ_DONE, 1'b1, 32'hFFFF_FFFF);
        send_event(OP_HEARTBEAT, 1'b1, 32'd5000);
        send_event(OP_READ_DONE, 1'b1, 32'd5000);
        send_event(OP_QUALITY, 1'b0, 32'd5001);
        send_event(OP_QUALITY, 1'b1, 32'd5002);
    endtask

    task automatic test_reconnect();
        apply_settings(1'b1, 1'b1);
        for (int i = 0; i < 9; i++)
            send_event(OP_HEARTBEAT, 1'b0, 32'd6000 + i);
        send_event(OP_LINK, 1'b0, 32'd6100);
        send_event(OP_LINK, 1'b0, 32'd6101);
        send_event(OP_LINK, 1'b1, 32'd6102);
        for (int i = 0; i < 3; i++)
            send_event(OP_ERROR, 1'b1, 32'd6200 + i);
        send_event(OP_ERROR, 1'b0, 32'd6210);
        send_event(OP_RETRY, 1'b0, 32'd6300);
        send_event(OP_RETRY, 1'b1, 32'd6301);
        send_event(OP_QUALITY, 1'b1, 32'd6400);
    endtask

    task automatic test_failure_saturation();
        apply_settings(1'b0, 1'b0);
        for (int i = 0; i < 258; i++)
            send_event(op_t'($urandom_range(OP_READ_DONE, OP_ERROR)), 1'b0, $urandom());
        send_event(OP_RETRY, 1'b1, 32'd7000);
        send_event(OP_LINK, 1'b1, 32'd7001);
    endtask

    task automatic run_random_traffic(int n_items);
        int          sent;
        int          pick;
        int          spread;
        logic [31:0] gap;
        sent   = 0;
        spread = 900;
        while (sent < n_items) begin
            // move the response-time regime so the average crosses every class
            if ($urandom_range(39) == 0) begin
                case ($urandom_range(3))
                    0: spread = 900;
                    1: spread = 2900;
                    2: spread = 7900;
                    default: spread = 20000;
                endcase
            end
            now_ms += $urandom_range(1, 40);
            if ($urandom_range(24) == 0)
                now_ms += $urandom();
            pick = $urandom_range(99);
            if (pick < 40) begin
                gap = ($urandom_range(49) == 0) ? $urandom() : $urandom_range(spread);
                send_event(OP_HEARTBEAT, 1'b1, now_ms);
                now_ms += gap;
                send_event(OP_READ_DONE, 1'b1, now_ms);
                sent += 2;
            end else if (pick < 50) begin
                send_event(OP_QUALITY, $urandom_range(1), now_ms);
                sent++;
            end else if (pick < 58) begin
                repeat ($urandom_range(1, 5)) begin
                    send_event(OP_ERROR, $urandom_range(1), now_ms);
                    sent++;
                end
            end else begin
                send_event(op_t'($urandom_range(6)), $urandom_range(1), now_ms);
                sent++;
            end
        end
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 36; recv_idle_pct = 81; end
                1: begin send_idle_pct = 81; recv_idle_pct = 36; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            apply_settings(1'b1, 1'b1);
            run_random_traffic(330);
            case (ph)
                0: apply_settings(1'b1, 1'b0);
                1: apply_settings(1'b0, 1'b1);
                default: apply_settings(1'b0, 1'b0);
            endcase
            run_random_traffic(150);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_monitoring_off();
        test_response_window();
        test_reconnect();
        test_failure_saturation();
        test_random_phases();
        drain_results();
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
